### src/emx_pkg.sv
`timescale 1ns / 1ps
package emx_pkg;
    localparam int MOD_BITS = 17;
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(EXP_BITS + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [MOD_BITS-1:0] P_RESET = MOD_BITS'(65537);
    localparam logic [MOD_BITS-1:0] G_RESET = MOD_BITS'(3);

    localparam logic [1:0] CMD_KEYGEN  = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN   = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key_value;
        logic [31:0] message_value;
        logic [31:0] cipher_first;
        logic [31:0] nonce;
    } t_in;

    typedef struct packed {
        logic [MOD_BITS-1:0] result_first;
        logic [MOD_BITS-1:0] result_second;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_CLEAR_OUT,
        OP_RED_GEN, OP_RED_KEY, OP_RED_CA, OP_RED_MSG,
        OP_MUL_AB, OP_MUL_BB, OP_MUL_TA,
        OP_WB_ACC, OP_WB_SQ, OP_WB_BASE, OP_WB_T,
        OP_EXP_KEY, OP_EXP_NONCE, OP_EXP_PM2,
        OP_BASE_ACC, OP_SAVE0_ACC, OP_OUT0_U, OP_OUT1_U
    } t_dp_op;

    typedef struct packed {
        logic       u_done;
        logic       exp_zero;
        logic       exp_lsb;
        logic       p_small;
        logic [1:0] cmd;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EXP_RED, S_EXP_RED_W, S_EXP_INIT, S_EXP_CHECK,
        S_MUL_W, S_SQ, S_SQ_W, S_EXP_END, S_T_W, S_TMUL, S_TMUL_W, S_EMIT
    } t_state;

    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_INV} t_phase;
endpackage

### src/emx_datapath.sv
`timescale 1ns / 1ps
module emx_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  emx_pkg::t_dp_op                 i_op,
    input  emx_pkg::t_in                    i_in,
    input  logic                            i_cfg_we,
    input  logic [emx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [emx_pkg::MOD_BITS-1:0]    i_cfg_data,
    output emx_pkg::t_dp_status             o_status,
    output emx_pkg::t_out                   o_out
);
    import emx_pkg::*;

    localparam int W2 = MOD_BITS + 2;

    logic [MOD_BITS-1:0] r_p, r_g;
    t_in                 r_in;
    logic [MOD_BITS-1:0] r_acc, r_base, r_t, r_out0, r_out1;
    logic [EXP_BITS-1:0] r_exp;

    logic [MOD_BITS-1:0] r_u_acc, r_u_a;
    logic [EXP_BITS-1:0] r_u_b;
    logic [CNT_W-1:0]    r_u_cnt;
    logic                r_u_busy, r_u_done;

    logic [W2-1:0]       t_sum, p1, p2, t_red;
    logic [MOD_BITS-1:0] n_u_acc;

    always_comb begin
        p1 = W2'(r_p);
        p2 = W2'({r_p, 1'b0});
        t_sum = W2'({r_u_acc, 1'b0}) + (r_u_b[EXP_BITS-1] ? W2'(r_u_a) : W2'(0));
        if (t_sum >= p2) begin
            t_red = t_sum - p2;
        end else if (t_sum >= p1) begin
            t_red = t_sum - p1;
        end else begin
            t_red = t_sum;
        end
        n_u_acc = t_red[MOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p      <= P_RESET;
            r_g      <= G_RESET;
            r_u_busy <= 1'b0;
            r_u_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PRIME: r_p <= i_cfg_data;
                    REG_GEN:   r_g <= i_cfg_data;
                    default: ;
                endcase
            end
            r_u_done <= 1'b0;
            if (r_u_busy) begin
                r_u_acc <= n_u_acc;
                r_u_b   <= {r_u_b[EXP_BITS-2:0], 1'b0};
                r_u_cnt <= r_u_cnt - CNT_W'(1);
                if (r_u_cnt == CNT_W'(1)) begin
                    r_u_busy <= 1'b0;
                    r_u_done <= 1'b1;
                end
            end
            unique case (i_op)
                OP_RED_GEN, OP_RED_KEY, OP_RED_CA, OP_RED_MSG: begin
                    r_u_busy <= 1'b1;
                    r_u_acc  <= '0;
                    r_u_a    <= MOD_BITS'(1);
                    r_u_cnt  <= CNT_W'(EXP_BITS);
                end
                OP_MUL_AB, OP_MUL_BB, OP_MUL_TA: begin
                    r_u_busy <= 1'b1;
                    r_u_acc  <= '0;
                    r_u_cnt  <= CNT_W'(MOD_BITS);
                end
                default: ;
            endcase
            unique case (i_op)
                OP_RED_GEN: r_u_b <= EXP_BITS'(r_g);
                OP_RED_KEY: r_u_b <= EXP_BITS'(r_in.key_value);
                OP_RED_CA:  r_u_b <= EXP_BITS'(r_in.cipher_first);
                OP_RED_MSG: r_u_b <= EXP_BITS'(r_in.message_value);
                OP_MUL_AB: begin
                    r_u_a <= r_acc;
                    r_u_b <= {r_base, {(EXP_BITS-MOD_BITS){1'b0}}};
                end
                OP_MUL_BB: begin
                    r_u_a <= r_base;
                    r_u_b <= {r_base, {(EXP_BITS-MOD_BITS){1'b0}}};
                end
                OP_MUL_TA: begin
                    r_u_a <= r_t;
                    r_u_b <= {r_acc, {(EXP_BITS-MOD_BITS){1'b0}}};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH:     r_in <= i_in;
            OP_CLEAR_OUT: begin
                r_out0 <= '0;
                r_out1 <= '0;
            end
            OP_WB_ACC:    r_acc <= r_u_acc;
            OP_WB_BASE:   r_base <= r_u_acc;
            OP_WB_SQ: begin
                r_base <= r_u_acc;
                r_exp  <= r_exp >> 1;
            end
            OP_WB_T:      r_t <= r_u_acc;
            OP_EXP_KEY: begin
                r_acc <= MOD_BITS'(1);
                r_exp <= EXP_BITS'(r_in.key_value);
            end
            OP_EXP_NONCE: begin
                r_acc <= MOD_BITS'(1);
                r_exp <= EXP_BITS'(r_in.nonce);
            end
            OP_EXP_PM2: begin
                r_acc <= MOD_BITS'(1);
                r_exp <= EXP_BITS'(r_p - MOD_BITS'(2));
            end
            OP_BASE_ACC:  r_base <= r_acc;
            OP_SAVE0_ACC: r_out0 <= r_acc;
            OP_OUT0_U:    r_out0 <= r_u_acc;
            OP_OUT1_U:    r_out1 <= r_u_acc;
            default: ;
        endcase
    end

    assign o_status.u_done   = r_u_done;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.p_small  = (r_p <= MOD_BITS'(1));
    assign o_status.cmd      = r_in.cmd;
    assign o_out.result_first  = r_out0;
    assign o_out.result_second = r_out1;
endmodule

### src/emx_controller.sv
`timescale 1ns / 1ps
module emx_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  emx_pkg::t_dp_status  i_status,
    output emx_pkg::t_dp_op      o_op,
    output logic                 o_busy,
    output logic                 o_done
);
    import emx_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FIRST;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE:      if (i_start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                n_phase = PH_FIRST;
                if (i_status.p_small || i_status.cmd == CMD_UNUSED) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_EXP_RED;
                end
            end
            S_EXP_RED:   n_state = (r_phase == PH_INV) ? S_EXP_INIT : S_EXP_RED_W;
            S_EXP_RED_W: if (i_status.u_done) n_state = S_EXP_INIT;
            S_EXP_INIT:  n_state = S_EXP_CHECK;
            S_EXP_CHECK: begin
                priority if (i_status.exp_zero) n_state = S_EXP_END;
                else if (i_status.exp_lsb) n_state = S_MUL_W;
                else n_state = S_SQ;
            end
            S_MUL_W:     if (i_status.u_done) n_state = S_SQ;
            S_SQ:        n_state = S_SQ_W;
            S_SQ_W:      if (i_status.u_done) n_state = S_EXP_CHECK;
            S_EXP_END: begin
                priority if (r_phase != PH_FIRST) begin
                    n_state = S_T_W;
                end else if (i_status.cmd == CMD_ENCRYPT) begin
                    n_phase = PH_SECOND;
                    n_state = S_EXP_RED;
                end else if (i_status.cmd == CMD_DECRYPT) begin
                    n_phase = PH_INV;
                    n_state = S_EXP_RED;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_T_W:       if (i_status.u_done) n_state = S_TMUL;
            S_TMUL:      n_state = S_TMUL_W;
            S_TMUL_W:    if (i_status.u_done) n_state = S_EMIT;
            S_EMIT:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = OP_NONE;
        o_busy = (r_state != S_IDLE);
        o_done = (r_state == S_EMIT);
        unique case (r_state)
            S_IDLE:      if (i_start) o_op = OP_LATCH;
            S_DISPATCH:  o_op = OP_CLEAR_OUT;
            S_EXP_RED: begin
                priority if (r_phase == PH_INV) o_op = OP_BASE_ACC;
                else if (r_phase == PH_SECOND) o_op = OP_RED_KEY;
                else if (i_status.cmd == CMD_DECRYPT) o_op = OP_RED_CA;
                else o_op = OP_RED_GEN;
            end
            S_EXP_RED_W: if (i_status.u_done) o_op = OP_WB_BASE;
            S_EXP_INIT: begin
                priority if (r_phase == PH_INV) o_op = OP_EXP_PM2;
                else if (i_status.cmd == CMD_ENCRYPT) o_op = OP_EXP_NONCE;
                else o_op = OP_EXP_KEY;
            end
            S_EXP_CHECK: if (!i_status.exp_zero && i_status.exp_lsb) o_op = OP_MUL_AB;
            S_MUL_W:     if (i_status.u_done) o_op = OP_WB_ACC;
            S_SQ:        o_op = OP_MUL_BB;
            S_SQ_W:      if (i_status.u_done) o_op = OP_WB_SQ;
            S_EXP_END: begin
                priority if (r_phase != PH_FIRST) o_op = OP_RED_MSG;
                else if (i_status.cmd == CMD_DECRYPT) o_op = OP_NONE;
                else o_op = OP_SAVE0_ACC;
            end
            S_T_W:       if (i_status.u_done) o_op = OP_WB_T;
            S_TMUL:      o_op = OP_MUL_TA;
            S_TMUL_W: begin
                if (i_status.u_done) o_op = (r_phase == PH_SECOND) ? OP_OUT1_U : OP_OUT0_U;
            end
            S_EMIT:      o_op = OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end
endmodule

### src/elgamal_modexp_engine.sv
`timescale 1ns / 1ps
// Modular multiplies and 32-bit operand reductions run bit-serially in one shared unit; an exponent
// costs one square per bit up to its top set bit plus one multiply per set bit.
// The longest command is an encrypt with an all-ones nonce; when p <= 1 or for the unused
// command the engine skips all arithmetic and returns zero results.
// Throughput: one command at a time; busy drops the cycle after the result beat and the
// receiver cannot stall. Reset: synchronous active low; p = 65537, g = 3, controller idle.
module elgamal_modexp_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  emx_pkg::t_in                    i_in,
    output logic                            o_done,
    output emx_pkg::t_out                   o_out,
    input  logic                            i_cfg_we,
    input  logic [emx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [emx_pkg::MOD_BITS-1:0]    i_cfg_data
);
    import emx_pkg::*;

    t_dp_op     w_op;
    t_dp_status w_status;

    emx_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    emx_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (w_status),
        .o_out       (o_out)
    );
endmodule
